### rtl/core/ptw_pkg.sv
// Package for the three-level page-table walker.
// Holds field widths, index positions, status and operation codes, and the sequencer states.
// No dependencies.
package ptw_pkg;

  localparam int unsigned VA_W     = 39;
  localparam int unsigned PA_W     = 48;
  localparam int unsigned PPN_W    = 36;
  localparam int unsigned IDX_W    = 9;
  localparam int unsigned OFS_W    = 12;
  localparam int unsigned ENTRY_W  = 64;
  localparam int unsigned ENTRIES_PER_TABLE = 512;

  localparam int unsigned ROOT_LSB = 30;
  localparam int unsigned MID_LSB  = 21;
  localparam int unsigned LEAF_LSB = 12;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FAULT = 2'd1;
  localparam logic [1:0] ST_REMAP = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic OP_TRANSLATE = 1'b0;
  localparam logic OP_MAP       = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ROOT,
    S_MID,
    S_LEAF,
    S_DONE
  } state_t;

endpackage

### rtl/core/ptw_store.sv
// Table store: one write port, one read port with registered read data.
// Forwards write data when a read hits the address written in the same cycle.
// Uses ptw_pkg for the entry width.
module ptw_store #(
  parameter int unsigned AW    = 12,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [ptw_pkg::ENTRY_W-1:0]   wdata,
  input  logic [AW-1:0]                 raddr,
  output logic [ptw_pkg::ENTRY_W-1:0]   rdata
);

  logic [ptw_pkg::ENTRY_W-1:0] mem [DEPTH];
  logic [ptw_pkg::ENTRY_W-1:0] mem_q;
  logic [ptw_pkg::ENTRY_W-1:0] fwd_data;
  logic                        fwd_hit;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    mem_q    <= mem[raddr];
    fwd_hit  <= we && (waddr == raddr);
    fwd_data <= wdata;
  end

  assign rdata = fwd_hit ? fwd_data : mem_q;

endmodule

### rtl/core/three_level_page_table_walker_top.sv
// Top level of the three-level page-table walker: sequencer, allocator and result register.
// Uses ptw_pkg and ptw_store.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one item: operation, vaddr, paddr, perm_low,
//   perm_high. Output channel (out_valid/out_ready) gives one item per input item: status,
//   paddr_out, tlb_invalidate. cfg_write/cfg_data set the base page number of store page 0;
//   write it only while the block is idle.
//   Each item walks root, mid and leaf entries through the single read port of the table
//   store, one dependent read per cycle. An item that runs the full walk passes the root,
//   mid, leaf and done states before its result shows on out_valid; a fault or a full
//   store at the root or mid level ends the walk early. in_ready rises again as the result
//   is loaded into the output register, so no new item is taken while one is in the walk.
//   Reset clears control state and starts a clearing pass that writes zero to every store
//   entry, one entry per cycle; in_ready stays low until it ends.
//   Configuration writes are taken during the pass.
//   When the receiver stalls, the finished result holds in the output register and the
//   next result waits in the sequencer until the output register is free.
module three_level_page_table_walker_top #(
  parameter int unsigned TABLE_PAGES = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [ptw_pkg::PPN_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        operation,
  input  logic [ptw_pkg::VA_W-1:0]    vaddr,
  input  logic [ptw_pkg::PA_W-1:0]    paddr,
  input  logic [ptw_pkg::OFS_W-1:0]   perm_low,
  input  logic [1:0]                  perm_high,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic [ptw_pkg::PA_W-1:0]    paddr_out,
  output logic                        tlb_invalidate
);

  localparam int unsigned PW    = $clog2(TABLE_PAGES);
  localparam int unsigned NW    = $clog2(TABLE_PAGES + 1);
  localparam int unsigned AW    = PW + ptw_pkg::IDX_W;
  localparam int unsigned DEPTH = TABLE_PAGES * ptw_pkg::ENTRIES_PER_TABLE;

  ptw_pkg::state_t state, state_next;

  logic [ptw_pkg::PPN_W-1:0] base;
  logic [NW-1:0]             nfp, nfp_next;
  logic [PW-1:0]             cur_page, page_next;
  logic [AW-1:0]             clr_addr;

  logic                      op_q;
  logic [ptw_pkg::VA_W-1:0]  va_q;
  logic [ptw_pkg::PPN_W-1:0] pa_q;
  logic [ptw_pkg::OFS_W-1:0] plo_q;
  logic [1:0]                phi_q;

  logic [1:0]                res_status, res_status_next;
  logic [ptw_pkg::PA_W-1:0]  res_paddr, res_paddr_next;
  logic                      res_inval, res_inval_next;

  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [ptw_pkg::ENTRY_W-1:0] mem_wdata;
  logic [AW-1:0]               mem_raddr;
  logic [ptw_pkg::ENTRY_W-1:0] mem_rdata;

  logic [ptw_pkg::PPN_W-1:0] dir_off;
  logic [ptw_pkg::PPN_W-1:0] alloc_ppn;
  logic                      dir_in;
  logic                      ent_zero;
  logic                      full;
  logic [ptw_pkg::IDX_W-1:0] lvl_idx;
  logic [ptw_pkg::IDX_W-1:0] nxt_idx;
  logic                      out_free;

  ptw_store #(
    .AW    (AW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_ready  = (state == ptw_pkg::S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign ent_zero  = (mem_rdata == '0);
  assign dir_off   = mem_rdata[ptw_pkg::PA_W-1:ptw_pkg::OFS_W] - base;
  assign dir_in    = (dir_off < ptw_pkg::PPN_W'(TABLE_PAGES));
  assign full      = (nfp >= NW'(TABLE_PAGES));
  assign alloc_ppn = base + ptw_pkg::PPN_W'(nfp);
  assign lvl_idx   = (state == ptw_pkg::S_ROOT) ?
                     va_q[ptw_pkg::ROOT_LSB +: ptw_pkg::IDX_W] :
                     va_q[ptw_pkg::MID_LSB +: ptw_pkg::IDX_W];
  assign nxt_idx   = (state == ptw_pkg::S_ROOT) ?
                     va_q[ptw_pkg::MID_LSB +: ptw_pkg::IDX_W] :
                     va_q[ptw_pkg::LEAF_LSB +: ptw_pkg::IDX_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ptw_pkg::S_CLEAR;
      base      <= '0;
      nfp       <= NW'(1);
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      nfp   <= nfp_next;
      if (cfg_write) begin
        base <= cfg_data;
      end
      if (state == ptw_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (state == ptw_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_page   <= page_next;
    res_status <= res_status_next;
    res_paddr  <= res_paddr_next;
    res_inval  <= res_inval_next;
    if (in_valid && in_ready) begin
      op_q  <= operation;
      va_q  <= vaddr;
      pa_q  <= paddr[ptw_pkg::PA_W-1:ptw_pkg::OFS_W];
      plo_q <= perm_low;
      phi_q <= perm_high;
    end
    if (state == ptw_pkg::S_DONE && out_free) begin
      status         <= res_status;
      paddr_out      <= res_paddr;
      tlb_invalidate <= res_inval;
    end
  end

  always_comb begin
    state_next      = state;
    nfp_next        = nfp;
    page_next       = cur_page;
    res_status_next = res_status;
    res_paddr_next  = res_paddr;
    res_inval_next  = res_inval;
    mem_we          = 1'b0;
    mem_waddr       = {cur_page, lvl_idx};
    mem_wdata       = '0;
    mem_raddr       = {PW'(0), vaddr[ptw_pkg::ROOT_LSB +: ptw_pkg::IDX_W]};
    unique case (state)
      ptw_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = ptw_pkg::S_IDLE;
        end
      end
      ptw_pkg::S_IDLE: begin
        if (in_valid) begin
          page_next       = '0;
          res_status_next = ptw_pkg::ST_OK;
          res_paddr_next  = '0;
          res_inval_next  = 1'b0;
          state_next      = ptw_pkg::S_ROOT;
        end
      end
      ptw_pkg::S_ROOT, ptw_pkg::S_MID: begin
        if (!ent_zero) begin
          if (dir_in) begin
            page_next = dir_off[PW-1:0];
          end else begin
            res_status_next = ptw_pkg::ST_FAULT;
          end
        end else if (op_q != ptw_pkg::OP_MAP) begin
          res_status_next = ptw_pkg::ST_FAULT;
        end else if (full) begin
          res_status_next = ptw_pkg::ST_FULL;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = {16'b0, alloc_ppn, 12'b0};
          page_next = nfp[PW-1:0];
          nfp_next  = nfp + NW'(1);
        end
        mem_raddr = {page_next, nxt_idx};
        if ((!ent_zero && !dir_in) || (ent_zero && (op_q != ptw_pkg::OP_MAP || full))) begin
          state_next = ptw_pkg::S_DONE;
        end else if (state == ptw_pkg::S_ROOT) begin
          state_next = ptw_pkg::S_MID;
        end else begin
          state_next = ptw_pkg::S_LEAF;
        end
      end
      ptw_pkg::S_LEAF: begin
        mem_waddr = {cur_page, va_q[ptw_pkg::LEAF_LSB +: ptw_pkg::IDX_W]};
        mem_wdata = {1'b0, phi_q[1], phi_q[0], 13'b0, pa_q, plo_q};
        if (op_q != ptw_pkg::OP_MAP) begin
          if (mem_rdata[0]) begin
            res_paddr_next = {mem_rdata[ptw_pkg::PA_W-1:ptw_pkg::OFS_W],
                              va_q[ptw_pkg::OFS_W-1:0]};
          end else begin
            res_status_next = ptw_pkg::ST_FAULT;
          end
        end else if (mem_rdata[0]) begin
          res_status_next = ptw_pkg::ST_REMAP;
        end else begin
          mem_we         = 1'b1;
          res_inval_next = 1'b1;
        end
        state_next = ptw_pkg::S_DONE;
      end
      ptw_pkg::S_DONE: begin
        if (out_free) begin
          state_next = ptw_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ptw_pkg::S_CLEAR;
      end
    endcase
  end

  a_nfp_range: assert property (@(posedge clk) disable iff (rst)
    (nfp >= NW'(1)) && (nfp <= NW'(TABLE_PAGES)))
    else $error("free page counter out of range");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while walk in progress");

  a_inval_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && tlb_invalidate) |-> (status == ptw_pkg::ST_OK))
    else $error("invalidate with failing status");

  a_paddr_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && paddr_out != '0) |-> (status == ptw_pkg::ST_OK && !tlb_invalidate))
    else $error("address returned without successful translate");

endmodule
